// File: src/qlt_pkg.sv
`default_nettype none

package qlt_pkg;

  // Default buffer depth and separator after reset
  localparam int        MAX_LEN_DEF = 64;
  localparam logic [7:0] SEP_RESET  = 8'd44;

  // Character codes
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_START,
    ST_SKIP_RD,
    ST_SKIP_EV,
    ST_Q_RD,
    ST_Q_EV,
    ST_U_RD,
    ST_U_EV,
    ST_E_RD,
    ST_E_EV,
    ST_FLUSH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store;     // write input byte into buffer
    logic clr;       // drop partly loaded string
    logic start;     // strip outer brackets, set scan bounds
    logic rd_i;      // read buffer at scan index
    logic rd_j;      // read buffer at probe index
    logic i_inc;     // advance scan index by one
    logic q_begin;   // open quoted token
    logic u_begin;   // open unquoted token
    logic j_inc1;    // advance probe by one
    logic j_inc2;    // advance probe past escaped byte
    logic t1_upd;    // move trimmed end behind probe
    logic emit_q;    // set bounds of a closed quoted token
    logic i_next;    // continue scan behind the probe
    logic push;      // hand one result item to the output
    logic push_has;  // pushed item carries the read byte
    logic push_end;  // pushed item closes a token
    logic flush;     // release final item of the string
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic i_lt_e;
    logic j_lt_e;
    logic c_blank;
    logic c_sep;
    logic c_quote;
    logic c_eq_qc;
    logic c_bslash;
    logic j_eq_i1;
    logic k_last;
    logic push_ok;
    logic flush_ok;
  } stat_t;

endpackage

`default_nettype wire

// File: src/qlt_ctrl.sv
`default_nettype none

module qlt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  input  wire logic          in_tlast,
  input  wire logic          in_tuser,
  output logic               in_tready,
  input  wire qlt_pkg::stat_t stat,
  output qlt_pkg::cmd_t      cmd
);
  import qlt_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_tuser) begin
            cmd.clr   = 1'b1;
            state_nxt = ST_FLUSH;
          end else begin
            cmd.store = 1'b1;
            if (in_tlast) state_nxt = ST_START;
          end
        end
      end
      ST_START: begin
        cmd.start = 1'b1;
        state_nxt = ST_SKIP_RD;
      end
      ST_SKIP_RD: begin
        if (stat.i_lt_e) begin
          cmd.rd_i  = 1'b1;
          state_nxt = ST_SKIP_EV;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_SKIP_EV: begin
        // skip blanks and separators, then pick token kind
        if (stat.c_blank || stat.c_sep) begin
          cmd.i_inc = 1'b1;
          state_nxt = ST_SKIP_RD;
        end else if (stat.c_quote) begin
          cmd.q_begin = 1'b1;
          state_nxt   = ST_Q_RD;
        end else begin
          cmd.u_begin = 1'b1;
          state_nxt   = ST_U_RD;
        end
      end
      ST_Q_RD: begin
        if (stat.j_lt_e) begin
          cmd.rd_j  = 1'b1;
          state_nxt = ST_Q_EV;
        end else begin
          // quote never closed: rescan as unquoted
          cmd.u_begin = 1'b1;
          state_nxt   = ST_U_RD;
        end
      end
      ST_Q_EV: begin
        if (stat.c_eq_qc) begin
          if (stat.j_eq_i1) begin
            // empty quoted token: one byte-less item
            if (stat.push_ok) begin
              cmd.push     = 1'b1;
              cmd.push_end = 1'b1;
              cmd.i_next   = 1'b1;
              state_nxt    = ST_SKIP_RD;
            end
          end else begin
            cmd.emit_q = 1'b1;
            state_nxt  = ST_E_RD;
          end
        end else if (stat.c_bslash) begin
          cmd.j_inc2 = 1'b1;
          state_nxt  = ST_Q_RD;
        end else begin
          cmd.j_inc1 = 1'b1;
          state_nxt  = ST_Q_RD;
        end
      end
      ST_U_RD: begin
        if (stat.j_lt_e) begin
          cmd.rd_j  = 1'b1;
          state_nxt = ST_U_EV;
        end else begin
          state_nxt = ST_E_RD;
        end
      end
      ST_U_EV: begin
        if (stat.c_sep) begin
          state_nxt = ST_E_RD;
        end else begin
          cmd.j_inc1 = 1'b1;
          cmd.t1_upd = !stat.c_blank;
          state_nxt  = ST_U_RD;
        end
      end
      ST_E_RD: begin
        cmd.rd_i  = 1'b1;
        state_nxt = ST_E_EV;
      end
      ST_E_EV: begin
        // emit one token byte, hold while the output is full
        if (stat.push_ok) begin
          cmd.push     = 1'b1;
          cmd.push_has = 1'b1;
          cmd.push_end = stat.k_last;
          if (stat.k_last) begin
            cmd.i_next = 1'b1;
            state_nxt  = ST_SKIP_RD;
          end else begin
            cmd.i_inc = 1'b1;
            state_nxt = ST_E_RD;
          end
        end
      end
      ST_FLUSH: begin
        if (stat.flush_ok) begin
          cmd.flush = 1'b1;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: src/qlt_dp.sv
`default_nettype none

module qlt_dp #(
  parameter int MAX_LEN = qlt_pkg::MAX_LEN_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_wr_en,
  input  wire logic [7:0]    cfg_wr_data,
  input  wire logic [7:0]    in_byte,
  input  wire qlt_pkg::cmd_t cmd,
  output qlt_pkg::stat_t     stat,
  input  wire logic          out_tready,
  output logic               out_tvalid,
  output logic [7:0]         out_byte,
  output logic               out_has,
  output logic               out_end,
  output logic               out_last,
  output logic               out_ov
);
  import qlt_pkg::*;

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 2);
  localparam logic [CW-1:0] ONE = CW'(1);
  localparam logic [CW-1:0] TWO = CW'(2);
  localparam logic [CW-1:0] LEN = CW'(MAX_LEN);

  logic [7:0]    mem [MAX_LEN];
  logic [7:0]    rdata_r;
  logic [7:0]    sep_r;
  logic [CW-1:0] fill_r;
  logic          ov_r;
  logic [7:0]    first_r, lastb_r;
  logic [CW-1:0] i_r, j_r, b_r, e_r;
  logic [7:0]    qc_r;
  logic          pend_v_r;
  logic [7:0]    pend_byte_r;
  logic          pend_has_r, pend_end_r;
  logic          out_valid_r;
  logic [7:0]    out_byte_r;
  logic          out_has_r, out_end_r, out_last_r, out_ov_r;

  logic          out_free;
  logic          strip;
  logic [AW-1:0] rd_addr;

  // Separator register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sep_r <= SEP_RESET;
    end else if (cfg_wr_en) begin
      sep_r <= cfg_wr_data;
    end
  end

  // Buffer write and registered read
  assign rd_addr = cmd.rd_j ? j_r[AW-1:0] : i_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.store && (fill_r < LEN)) begin
      mem[fill_r[AW-1:0]] <= in_byte;
    end
    if (cmd.rd_i || cmd.rd_j) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Fill count and overflow flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ov_r   <= 1'b0;
    end else if (cmd.clr || (cmd.flush && out_free)) begin
      fill_r <= '0;
      ov_r   <= 1'b0;
    end else if (cmd.store) begin
      if (fill_r < LEN) begin
        fill_r <= fill_r + ONE;
      end else begin
        ov_r <= 1'b1;
      end
    end
  end

  // Capture first and last stored bytes for bracket stripping
  always_ff @(posedge clk) begin
    if (cmd.store && (fill_r < LEN)) begin
      lastb_r <= in_byte;
      if (fill_r == '0) first_r <= in_byte;
    end
  end

  assign strip = ((first_r == CH_LPAREN) && (lastb_r == CH_RPAREN)) ||
                 ((first_r == CH_LBRACK) && (lastb_r == CH_RBRACK)) ||
                 ((first_r == CH_LBRACE) && (lastb_r == CH_RBRACE));

  // Scan indexes
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      i_r <= strip ? ONE : '0;
      e_r <= strip ? (fill_r - ONE) : fill_r;
    end else if (cmd.i_next) begin
      i_r <= j_r + ONE;
    end else if (cmd.i_inc || cmd.emit_q) begin
      i_r <= i_r + ONE;
    end

    if (cmd.q_begin || cmd.u_begin) begin
      j_r <= i_r + ONE;
    end else if (cmd.j_inc2) begin
      j_r <= j_r + TWO;
    end else if (cmd.j_inc1) begin
      j_r <= j_r + ONE;
    end

    if (cmd.u_begin) begin
      b_r <= i_r + ONE;
    end else if (cmd.emit_q) begin
      b_r <= j_r;
    end else if (cmd.t1_upd) begin
      b_r <= j_r + ONE;
    end

    if (cmd.q_begin) begin
      qc_r <= rdata_r;
    end
  end

  // Status toward the controller
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    stat          = '0;
    stat.i_lt_e   = (i_r < e_r);
    stat.j_lt_e   = (j_r < e_r);
    stat.c_blank  = (rdata_r == CH_SPACE) || (rdata_r == CH_TAB) || (rdata_r == CH_NL);
    stat.c_sep    = (rdata_r == sep_r);
    stat.c_quote  = (rdata_r == CH_SQUOTE) || (rdata_r == CH_DQUOTE);
    stat.c_eq_qc  = (rdata_r == qc_r);
    stat.c_bslash = (rdata_r == CH_BSLASH);
    stat.j_eq_i1  = (j_r == (i_r + ONE));
    stat.k_last   = ((i_r + ONE) == b_r);
    stat.push_ok  = !pend_v_r || out_free;
    stat.flush_ok = out_free;
  end

  // One item of lookahead so the final item can carry last
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (cmd.flush && out_free) begin
      pend_v_r <= 1'b0;
    end else if (cmd.push && stat.push_ok) begin
      pend_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && stat.push_ok) begin
      pend_byte_r <= cmd.push_has ? rdata_r : 8'd0;
      pend_has_r  <= cmd.push_has;
      pend_end_r  <= cmd.push_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((cmd.flush && out_free) || (cmd.push && pend_v_r && out_free)) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.flush && out_free) begin
      out_byte_r <= pend_v_r ? pend_byte_r : 8'd0;
      out_has_r  <= pend_v_r && pend_has_r;
      out_end_r  <= pend_v_r && pend_end_r;
      out_last_r <= 1'b1;
      out_ov_r   <= ov_r;
    end else if (cmd.push && pend_v_r && out_free) begin
      out_byte_r <= pend_byte_r;
      out_has_r  <= pend_has_r;
      out_end_r  <= pend_end_r;
      out_last_r <= 1'b0;
      out_ov_r   <= ov_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_byte   = out_byte_r;
  assign out_has    = out_has_r;
  assign out_end    = out_end_r;
  assign out_last   = out_last_r;
  assign out_ov     = out_ov_r;

  // Checks
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEN)
    else $error("fill count beyond buffer depth");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (!pend_v_r || out_free))
    else $error("push with lookahead and output both full");

  a_read_i: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_i |-> (i_r < fill_r))
    else $error("read at scan index beyond loaded bytes");

  a_read_j: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_j |-> (j_r < fill_r))
    else $error("read at probe index beyond loaded bytes");

  a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.flush && out_free) |=> (!pend_v_r && (fill_r == '0) && out_valid_r && out_last_r))
    else $error("flush left state behind");

endmodule

`default_nettype wire

// File: src/quoted_list_tokenizer.sv
`default_nettype none

// Quoted list tokenizer.
// Input channel in_*: one string byte per item in in_tdata; in_tlast marks the
// final byte, in_tuser marks an empty string (no byte, one end marker out).
// Output channel out_*: one item per token byte, or a byte-less item for an
// empty quoted token or for a string with no tokens. out_tlast flags the
// final item of the string; out_tuser carries has_byte, token_end, overflow.
// cfg_wr_en/cfg_wr_data write the separator byte (comma after reset).
// in_tready is high only while loading, and each byte offered then is taken.
// After the final byte the buffer is scanned through its single read port,
// each read issued in a read state and evaluated in an evaluate state: each
// byte within the scan bounds is read at most once while scanning (a byte
// behind a backslash in a quoted token is skipped), the bytes of an unclosed
// quoted token once more when they are rescanned as unquoted, and token bytes
// once more while emitting. A scan starts with a setup step, ends when the scan
// index reaches the end of the bounds, and then releases the final item.
// Bytes past MAX_LEN are dropped and flag overflow on every item.
// Reset clears the load count, the overflow flag and the output; the
// separator returns to comma. A stalled receiver holds the output register
// and, once the one-item lookahead is also full, stops the scan in place.
module quoted_list_tokenizer #(
  parameter int MAX_LEN = qlt_pkg::MAX_LEN_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,    // [7:0] char_byte
  input  wire logic       in_tlast,    // last_byte
  input  wire logic       in_tuser,    // [0] empty_string
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,   // [7:0] token_byte
  output logic            out_tlast,   // last
  output logic [2:0]      out_tuser    // [0] has_byte, [1] token_end, [2] overflow
);
  import qlt_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  o_has, o_end, o_ov;

  qlt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  qlt_dp #(
    .MAX_LEN (MAX_LEN)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_byte     (in_tdata),
    .cmd         (cmd),
    .stat        (stat),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_byte    (out_tdata),
    .out_has     (o_has),
    .out_end     (o_end),
    .out_last    (out_tlast),
    .out_ov      (o_ov)
  );

  assign out_tuser = {o_ov, o_end, o_has};

endmodule

`default_nettype wire

// File: bench/quoted_list_tokenizer_tb.sv
`timescale 1ns / 100ps

module quoted_list_tokenizer_tb;
  import qlt_pkg::*;

  localparam int BUF_DEPTH = MAX_LEN_DEF;
  localparam int SETTLE    = 400;   // slowest scan of a full buffer
  localparam int WATCHDOG  = 4000;
  localparam int NDIR      = 15;
  localparam int NPHASE    = 7;
  localparam int PHASE_ITEMS = 3;

  // One token item as it leaves the block
  typedef struct packed {
    logic [7:0] tbyte;
    logic       has_byte;
    logic       tok_end;
    logic       str_last;
    logic       ovf;
  } tok_item_t;

  // Directed row: pad_n copies of pad_ch, then the row text
  typedef struct packed {
    logic [6:0] pad_n;
    logic [7:0] pad_ch;
    logic       term;
    logic       emp;
    logic       typed;
    tok_item_t  want;
  } dir_row_t;

  localparam tok_item_t END_MARK = '{8'h00, 1'b0, 1'b0, 1'b1, 1'b0};
  localparam tok_item_t NO_WANT  = '0;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;
  logic       in_tlast;
  logic       in_tuser;
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;
  logic       out_tlast;
  logic [2:0] out_tuser;

  quoted_list_tokenizer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // Mirror of the block state
  logic [7:0] str_buf [0:BUF_DEPTH-1];
  int         fill_n;
  bit         ovf_seen;
  logic [7:0] sep_reg;

  tok_item_t  fresh_q[$];
  tok_item_t  pending_tokens[$];
  logic [7:0] str_q[$];

  bit         want_armed;
  tok_item_t  want_item;
  int         idle_odds;
  int         in_taken;
  int         quiet_cycles;
  int         mism_count;
  int         hold_left;

  // Directed table
  string dir_txt [NDIR] = '{
    "", "", "", "x", " \t\n", "(a, b\t)", "[ 'p,q' ,\"\"]", "{'a\\'b'}",
    "\"ab, c", "(a]", "{}", "ab", "", ",q", "' ',x y ,"
  };
  dir_row_t dir_rows [NDIR] = '{
    '{7'd0,  8'h00, 1'b0, 1'b1, 1'b1, END_MARK},                        // empty string
    '{7'd1,  8'h00, 1'b1, 1'b0, 1'b1, '{8'h00, 1'b1, 1'b1, 1'b1, 1'b0}}, // zero byte
    '{7'd1,  8'hFF, 1'b1, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b1, 1'b1, 1'b0}}, // top byte
    '{7'd0,  8'h00, 1'b1, 1'b0, 1'b1, '{8'h78, 1'b1, 1'b1, 1'b1, 1'b0}}, // one letter
    '{7'd0,  8'h00, 1'b1, 1'b0, 1'b1, END_MARK},                        // blanks only
    '{7'd0,  8'h00, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{7'd0,  8'h00, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{7'd0,  8'h00, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{7'd0,  8'h00, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{7'd0,  8'h00, 1'b1, 1'b0, 1'b0, NO_WANT},
    '{7'd0,  8'h00, 1'b1, 1'b0, 1'b1, END_MARK},                        // bare brackets
    '{7'd0,  8'h00, 1'b0, 1'b0, 1'b0, NO_WANT},                         // partial load
    '{7'd0,  8'h00, 1'b0, 1'b1, 1'b1, END_MARK},                        // discards it
    '{7'd66, 8'h7A, 1'b1, 1'b0, 1'b0, NO_WANT},                         // overflow
    '{7'd0,  8'h00, 1'b1, 1'b0, 1'b0, NO_WANT}
  };

  logic [7:0] phase_sep [NPHASE] = '{8'h3B, 8'h00, 8'hFF, CH_SPACE, CH_SQUOTE, 8'h00,
                                     SEP_RESET};

  function automatic bit is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_NL;
  endfunction

  function automatic void add_result(logic [7:0] b, bit h, bit e);
    tok_item_t r;
    r = '{b, h, e, 1'b0, 1'b0};
    fresh_q.insert(fresh_q.size(), r);
  endfunction

  // Emit buffer bytes [a, b) as one token
  function automatic void add_token(int a, int b);
    if (b <= a) begin
      add_result(8'h00, 1'b0, 1'b1);
      return;
    end
    for (int k = a; k < b; k++)
      add_result(str_buf[k], 1'b1, k + 1 == b);
  endfunction

  // Load one input item; on the end of a string, tokenize it into fresh_q
  function automatic void tokenize_item(logic [7:0] ch, bit lst, bit emp);
    int s, e, i, j, t1;
    logic [7:0] c;
    fresh_q.delete();
    if (emp) begin
      fill_n = 0;
      ovf_seen = 1'b0;
      fresh_q.insert(fresh_q.size(), END_MARK);
      return;
    end
    if (fill_n < BUF_DEPTH) begin
      str_buf[fill_n] = ch;
      fill_n++;
    end else begin
      ovf_seen = 1'b1;
    end
    if (!lst) return;

    // strip one matching outer bracket pair
    s = 0;
    e = fill_n;
    if ((str_buf[0] == CH_LPAREN && str_buf[e-1] == CH_RPAREN) ||
        (str_buf[0] == CH_LBRACK && str_buf[e-1] == CH_RBRACK) ||
        (str_buf[0] == CH_LBRACE && str_buf[e-1] == CH_RBRACE)) begin
      s = 1;
      e = e - 1;
    end

    i = s;
    while (i < e) begin
      c = str_buf[i];
      if (is_blank(c) || c == sep_reg) begin
        i++;
        continue;
      end
      // quoted token runs to its closing quote, backslash skips one byte
      if (c == CH_SQUOTE || c == CH_DQUOTE) begin
        j = i + 1;
        while (j < e && str_buf[j] != c)
          j += (str_buf[j] == CH_BSLASH) ? 2 : 1;
        if (j < e) begin
          add_token(i + 1, j);
          i = j + 1;
          continue;
        end
      end
      // unquoted token, trailing blanks trimmed
      j = i;
      while (j < e && str_buf[j] != sep_reg) j++;
      t1 = j;
      while (t1 > i && is_blank(str_buf[t1-1])) t1--;
      add_token(i, t1);
      i = j + 1;
    end

    if (fresh_q.size() == 0) add_result(8'h00, 1'b0, 1'b0);
    fresh_q[fresh_q.size()-1].str_last = 1'b1;
    foreach (fresh_q[k]) fresh_q[k].ovf = ovf_seen;
    fill_n = 0;
    ovf_seen = 1'b0;
  endfunction

  function automatic void report_bad(string what, tok_item_t want, tok_item_t got);
    mism_count++;
    if (mism_count <= 10)
      $display({"%s: expected byte=%h has=%b end=%b last=%b ovf=%b, ",
                "got byte=%h has=%b end=%b last=%b ovf=%b"},
               what, want.tbyte, want.has_byte, want.tok_end, want.str_last, want.ovf,
               got.tbyte, got.has_byte, got.tok_end, got.str_last, got.ovf);
  endfunction

  // Sample both channels, predict and check
  always @(posedge clk) begin
    tok_item_t got;
    tok_item_t want;
    if (!rst_n) begin
      fill_n = 0;
      ovf_seen = 1'b0;
      sep_reg = SEP_RESET;
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_wr_en) begin
        sep_reg = cfg_wr_data;
        quiet_cycles = 0;
      end
      if (out_tvalid && out_tready) begin
        quiet_cycles = 0;
        got = '{out_tdata, out_tuser[0], out_tuser[1], out_tlast, out_tuser[2]};
        if (pending_tokens.size() == 0) begin
          report_bad("item with nothing pending", NO_WANT, got);
        end else begin
          want = pending_tokens.pop_front();
          if (got !== want) report_bad("token mismatch", want, got);
        end
      end
      if (in_tvalid && in_tready) begin
        quiet_cycles = 0;
        in_taken++;
        tokenize_item(in_tdata, in_tlast, in_tuser);
        if (fresh_q.size() != 0) begin
          if (want_armed) begin
            pending_tokens.insert(pending_tokens.size(), want_item);
            want_armed = 1'b0;
          end else begin
            foreach (fresh_q[k]) pending_tokens.insert(pending_tokens.size(), fresh_q[k]);
          end
        end
      end
      if (quiet_cycles >= WATCHDOG) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Receiver: stall in random bursts
  always @(negedge clk) begin
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      hold_left = $urandom_range(0, 11);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Drive one item, optionally after a gap; return once it is taken
  task automatic send_item(logic [7:0] ch, bit lst, bit emp);
    int taken0;
    if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= ch;
    in_tlast  <= lst;
    in_tuser  <= emp;
    taken0 = in_taken;
    do @(negedge clk); while (in_taken == taken0);
  endtask

  task automatic send_bytes(bit term);
    for (int k = 0; k < str_q.size(); k++)
      send_item(str_q[k], term && k == str_q.size() - 1, 1'b0);
  endtask

  task automatic send_empty();
    send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
  endtask

  task automatic wait_drained();
    while (pending_tokens.size() != 0) @(negedge clk);
  endtask

  // Change the separator once the block has gone quiet
  task automatic write_separator(logic [7:0] v);
    in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [7:0] blank_ch();
    case ($urandom_range(0, 2))
      0: return CH_SPACE;
      1: return CH_TAB;
      default: return CH_NL;
    endcase
  endfunction

  function automatic logic [7:0] word_ch();
    if ($urandom_range(0, 3) == 0) return 8'($urandom_range(8'h30, 8'h39));
    return 8'($urandom_range(8'h61, 8'h7A));
  endfunction

  // Random list: optional brackets (some mismatched), words, quoted tokens (some left open), blanks
  function automatic void build_list(logic [7:0] sep);
    int ntok, kind, brk;
    logic [7:0] q;
    logic [7:0] open_c [3] = '{CH_LPAREN, CH_LBRACK, CH_LBRACE};
    logic [7:0] close_c [3] = '{CH_RPAREN, CH_RBRACK, CH_RBRACE};
    str_q.delete();
    brk = $urandom_range(0, 4);
    if (brk < 3) str_q.insert(str_q.size(), open_c[brk]);
    ntok = $urandom_range(1, 4);
    for (int t = 0; t < ntok; t++) begin
      if (t > 0 || $urandom_range(0, 5) == 0) str_q.insert(str_q.size(), sep);
      if ($urandom_range(0, 2) == 0) str_q.insert(str_q.size(), blank_ch());
      kind = $urandom_range(0, 5);
      if (kind <= 2) begin
        for (int k = $urandom_range(1, 4); k > 0; k--) str_q.insert(str_q.size(), word_ch());
      end else if (kind <= 4) begin
        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
        str_q.insert(str_q.size(), q);
        for (int k = $urandom_range(0, 4); k > 0; k--) begin
          if ($urandom_range(0, 3) == 0) begin
            str_q.insert(str_q.size(), CH_BSLASH);
            case ($urandom_range(0, 2))
              0: str_q.insert(str_q.size(), q);
              1: str_q.insert(str_q.size(), CH_BSLASH);
              default: str_q.insert(str_q.size(), 8'h6E);
            endcase
          end else if ($urandom_range(0, 4) == 0) begin
            str_q.insert(str_q.size(), $urandom_range(0, 1) ? sep : blank_ch());
          end else begin
            str_q.insert(str_q.size(), word_ch());
          end
        end
        // leave some quotes open
        if ($urandom_range(0, 7) != 0) str_q.insert(str_q.size(), q);
      end
      if ($urandom_range(0, 2) == 0) str_q.insert(str_q.size(), blank_ch());
    end
    if (brk < 3) begin
      if ($urandom_range(0, 7) == 0) str_q.insert(str_q.size(), close_c[(brk + 1) % 3]);
      else str_q.insert(str_q.size(), close_c[brk]);
    end
  endfunction

  initial begin
    logic [7:0] sep;
    int mode, phase_start;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 8'h00;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    in_tlast    = 1'b0;
    in_tuser    = 1'b0;
    out_tready  = 1'b1;
    idle_odds   = 0;
    hold_left   = 0;
    in_taken    = 0;
    mism_count  = 0;
    want_armed  = 1'b0;
    want_item   = NO_WANT;

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    write_separator(SEP_RESET);

    // Directed rows
    idle_odds = 4;
    for (int r = 0; r < NDIR; r++) begin
      str_q.delete();
      repeat (dir_rows[r].pad_n) str_q.insert(str_q.size(), dir_rows[r].pad_ch);
      for (int k = 0; k < dir_txt[r].len(); k++) str_q.insert(str_q.size(), dir_txt[r][k]);
      want_armed = dir_rows[r].typed;
      want_item  = dir_rows[r].want;
      if (dir_rows[r].emp) send_empty();
      else send_bytes(dir_rows[r].term);
    end

    // Random phases, one separator each; the third and the last run without idling
    for (int p = 0; p < NPHASE; p++) begin
      sep = (p == 5) ? 8'($urandom_range(0, 255)) : phase_sep[p];
      write_separator(sep);
      idle_odds = (p == 2 || p == NPHASE - 1) ? 0 : $urandom_range(2, 6);
      phase_start = in_taken;
      while (in_taken - phase_start < PHASE_ITEMS) begin
        mode = $urandom_range(0, 15);
        if (mode == 0) begin
          send_empty();
        end else begin
          str_q.delete();
          if (mode == 1) begin
            for (int k = $urandom_range(1, 10); k > 0; k--)
              str_q.insert(str_q.size(), 8'($urandom_range(0, 255)));
          end else if (mode == 2 && $urandom_range(0, 2) == 0) begin
            // long string, often past the buffer depth
            for (int k = $urandom_range(50, 72); k > 0; k--)
              str_q.insert(str_q.size(), $urandom_range(0, 5) == 0 ? sep : word_ch());
          end else begin
            build_list(sep);
          end
          // abort a partly loaded string now and then
          if ($urandom_range(0, 15) == 0) begin
            send_bytes(1'b0);
            send_empty();
          end else begin
            send_bytes(1'b1);
          end
        end
      end
    end

    in_tvalid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (mism_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
